/* rtl/core/dics_pkg.sv */
// Shared types and constants of the discrete inverse CDF sampler.
package dics_pkg;

  localparam int unsigned TableSizeDefault  = 1024;
  localparam int unsigned WeightBitsDefault = 16;
  localparam int unsigned FracBitsDefault   = 24;
  localparam int unsigned IndexOutBits      = 10;
  localparam int unsigned FxOutBits         = 25;
  localparam int unsigned StatusBits        = 2;

  // Request types.
  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqSample = 1'b1;

  // Status codes.
  localparam logic [StatusBits-1:0] StatusOk    = 2'd0;
  localparam logic [StatusBits-1:0] StatusFull  = 2'd1;
  localparam logic [StatusBits-1:0] StatusEmpty = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StSearchRd,
    StSearchCmp,
    StPrevRd,
    StPrevWait,
    StDivInit,
    StDivRun,
    StProbInit,
    StProbRun,
    StResult
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the request
    logic do_load;     // write table entry and update totals
    logic set_quick;   // write a result that needs no search
    logic search_init; // start binary search
    logic probe_rd;    // read prefix at mid
    logic probe_step;  // narrow the search interval
    logic prev_rd;     // read previous prefix and current weight
    logic reused_init; // start reused sample division
    logic prob_init;   // start probability division
    logic div_step;    // one divider iteration
    logic reused_done; // store reused sample
    logic prob_done;   // store probability
    logic out_load;    // move result into output register
  } dics_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sample;
    logic quick;       // empty, zero total or single entry
    logic search_done;
    logic div_done;
    logic zero_weight;
  } dics_stat_t;

endpackage

/* rtl/core/dics_ctrl.sv */
// Controller state machine of the discrete inverse CDF sampler.
module dics_ctrl
  import dics_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  input  dics_stat_t stat_i,
  output dics_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign req_ready_o = (state_q == StIdle);

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (!stat_i.is_sample) begin
          cmd_o.do_load = 1'b1;
          state_d = StResult;
        end else if (stat_i.quick) begin
          cmd_o.set_quick = 1'b1;
          state_d = StResult;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d = StSearchRd;
        end
      end
      StSearchRd: begin
        if (stat_i.search_done) begin
          cmd_o.prev_rd = 1'b1;
          state_d = StPrevWait;
        end else begin
          cmd_o.probe_rd = 1'b1;
          state_d = StSearchCmp;
        end
      end
      StSearchCmp: begin
        cmd_o.probe_step = 1'b1;
        state_d = StSearchRd;
      end
      StPrevRd: begin
        state_d = StPrevWait;
      end
      StPrevWait: begin
        cmd_o.reused_init = 1'b1;
        state_d = StDivInit;
      end
      StDivInit: begin
        if (stat_i.zero_weight) begin
          cmd_o.reused_done = 1'b1;
          cmd_o.prob_init = 1'b1;
          state_d = StProbRun;
        end else begin
          cmd_o.div_step = 1'b1;
          state_d = StDivRun;
        end
      end
      StDivRun: begin
        if (stat_i.div_done) begin
          cmd_o.reused_done = 1'b1;
          cmd_o.prob_init = 1'b1;
          state_d = StProbRun;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StProbInit: begin
        state_d = StProbRun;
      end
      StProbRun: begin
        if (stat_i.div_done) begin
          cmd_o.prob_done = 1'b1;
          state_d = StResult;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StResult: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          rsp_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef SYNTHESIS
  // Requests are taken only while idle.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (state_q == StIdle)) else $error("ready outside idle");
  // A result is presented only after a result state.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == StResult)) else $error("bad result");
  // A pending result is not overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |-> !cmd_o.out_load) else $error("overwrite");
`endif

endmodule

/* rtl/core/dics_dp.sv */
// Datapath of the discrete inverse CDF sampler: tables, search and divider.
module dics_dp
  import dics_pkg::*;
#(
  parameter int unsigned TableSize  = TableSizeDefault,
  parameter int unsigned WeightBits = WeightBitsDefault,
  parameter int unsigned FracBits   = FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dics_cmd_t               cmd_i,
  output dics_stat_t              stat_o,
  input  logic                    req_type_i,
  input  logic                    first_i,
  input  logic [WeightBits-1:0]   weight_i,
  input  logic [FracBits-1:0]     uniform_i,
  output logic [IndexOutBits-1:0] index_o,
  output logic [FxOutBits-1:0]    probability_o,
  output logic [FxOutBits-1:0]    reused_sample_o,
  output logic [StatusBits-1:0]   status_o
);

  localparam int unsigned IdxW  = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int unsigned CntW  = $clog2(TableSize + 1);
  localparam int unsigned SumW  = WeightBits + CntW;
  localparam int unsigned ScW   = SumW + FracBits;   // scaled and shifted prefix
  localparam int unsigned QW    = FracBits + 1;
  localparam int unsigned NumW  = ScW;               // dividend width
  localparam int unsigned StepW = $clog2(NumW + 1);
  localparam int unsigned RemW  = SumW + 1;

  // Table memories, read data registered.
  logic [WeightBits-1:0] wmem [TableSize];
  logic [SumW-1:0]       pmem [TableSize];
  logic [WeightBits-1:0] wrd_q;
  logic [SumW-1:0]       prd_q;

  logic                  req_q;
  logic                  first_q;
  logic [WeightBits-1:0] w_q;
  logic [FracBits-1:0]   u_q;
  logic [CntW-1:0]       cnt_q;
  logic [SumW-1:0]       total_q;
  logic [IdxW-1:0]       lo_q, hi_q, mid;
  logic [ScW-1:0]        scaled_q;
  logic [ScW-1:0]        diff;
  logic [NumW-1:0]       num_q;
  logic [SumW-1:0]       den_q;
  logic [RemW-1:0]       rem_q, rem_sh;
  logic [QW-1:0]         quo_q;
  logic                  sat_q;
  logic [StepW-1:0]      step_q;
  logic [QW-1:0]         reused_q, prob_q;
  logic [IdxW-1:0]       ores_idx;
  logic [CntW-1:0]       cnt_eff;
  logic [SumW-1:0]       tot_eff;
  logic [IdxW-1:0]       rd_addr;
  logic                  rd_en;
  logic [QW-1:0]         one_fx;
  logic [IndexOutBits-1:0] idx_res_q;
  logic [StatusBits-1:0] st_res_q;

  assign one_fx = QW'(1) << FracBits;
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      first_q <= first_i;
      w_q     <= weight_i;
      u_q     <= uniform_i;
    end
  end

  assign cnt_eff = (first_q) ? '0 : cnt_q;
  assign tot_eff = (first_q) ? '0 : total_q;

  // Entry count and running total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.do_load) begin
      if (cnt_eff < CntW'(TableSize)) begin
        cnt_q   <= cnt_eff + CntW'(1);
        total_q <= tot_eff + SumW'(w_q);
      end else begin
        cnt_q   <= cnt_eff;
        total_q <= tot_eff;
      end
    end
  end

  // Table writes and single read port.
  assign rd_addr = cmd_i.probe_rd ? mid : (lo_q - IdxW'(1));
  assign rd_en   = cmd_i.probe_rd | cmd_i.prev_rd;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && (cnt_eff < CntW'(TableSize))) begin
      wmem[cnt_eff[IdxW-1:0]] <= w_q;
      pmem[cnt_eff[IdxW-1:0]] <= tot_eff + SumW'(w_q);
    end
    if (rd_en) begin
      prd_q <= pmem[rd_addr];
    end
    if (cmd_i.prev_rd) begin
      wrd_q <= wmem[lo_q];
    end
  end

  // Binary search and scaled value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_init) begin
      lo_q     <= '0;
      hi_q     <= IdxW'(cnt_q - CntW'(1));
      scaled_q <= ScW'(u_q) * ScW'(total_q);
    end else if (cmd_i.probe_step) begin
      if ({prd_q, {FracBits{1'b0}}} < scaled_q) begin
        lo_q <= mid + IdxW'(1);
      end else begin
        hi_q <= mid;
      end
    end
  end

  // Difference to the previous prefix, zero below it.
  always_comb begin
    logic [ScW-1:0] prev;
    prev = (lo_q == '0) ? '0 : {prd_q, {FracBits{1'b0}}};
    diff = (scaled_q < prev) ? '0 : (scaled_q - prev);
  end

  // Restoring divider, one quotient bit a cycle, saturating.
  assign rem_sh = {rem_q[RemW-2:0], num_q[NumW-1]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.reused_init) begin
      num_q  <= diff;
      den_q  <= SumW'(wrd_q);
      rem_q  <= '0;
      quo_q  <= '0;
      sat_q  <= 1'b0;
      step_q <= '0;
    end else if (cmd_i.prob_init) begin
      num_q  <= NumW'({wrd_q, {FracBits{1'b0}}});
      den_q  <= total_q;
      rem_q  <= '0;
      quo_q  <= '0;
      sat_q  <= 1'b0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      logic qb;
      qb = (rem_sh >= RemW'(den_q));
      rem_q  <= qb ? (rem_sh - RemW'(den_q)) : rem_sh;
      num_q  <= num_q << 1;
      step_q <= step_q + StepW'(1);
      if (sat_q || quo_q[QW-1]) begin
        sat_q <= 1'b1;
      end
      quo_q <= {quo_q[QW-2:0], qb};
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load) begin
      idx_res_q <= (cnt_eff < CntW'(TableSize)) ? IndexOutBits'(cnt_eff) : '0;
      st_res_q  <= (cnt_eff < CntW'(TableSize)) ? StatusOk : StatusFull;
      prob_q    <= '0;
      reused_q  <= '0;
    end else if (cmd_i.set_quick) begin
      idx_res_q <= '0;
      if ((cnt_q == '0) || (total_q == '0)) begin
        st_res_q <= StatusEmpty;
        prob_q   <= '0;
        reused_q <= '0;
      end else begin
        st_res_q <= StatusOk;
        prob_q   <= one_fx;
        reused_q <= QW'(u_q);
      end
    end else begin
      if (cmd_i.reused_done) begin
        idx_res_q <= IndexOutBits'(lo_q);
        st_res_q  <= StatusOk;
        if (stat_o.zero_weight) begin
          reused_q <= (diff > ScW'(one_fx)) ? one_fx : QW'(diff);
        end else begin
          reused_q <= (sat_q || quo_q > one_fx) ? one_fx : quo_q;
        end
      end
      if (cmd_i.prob_done) begin
        prob_q <= (sat_q || quo_q > one_fx) ? one_fx : quo_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      index_o         <= idx_res_q;
      probability_o   <= FxOutBits'(prob_q);
      reused_sample_o <= FxOutBits'(reused_q);
      status_o        <= st_res_q;
    end
  end

  assign ores_idx           = lo_q;
  assign stat_o.is_sample   = (req_q == ReqSample);
  assign stat_o.quick       = (cnt_q <= CntW'(1)) || (total_q == '0);
  assign stat_o.search_done = (ores_idx >= hi_q);
  assign stat_o.div_done    = (step_q == StepW'(NumW));
  assign stat_o.zero_weight = (wrd_q == '0);

`ifndef SYNTHESIS
  // The entry count never exceeds the table size.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableSize)) else $error("count overflow");
  // A search interval stays ordered.
  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe_step |=> (lo_q <= hi_q)) else $error("search order");
  // Divider never runs past its length.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (step_q < StepW'(NumW))) else $error("divider overrun");
`endif

endmodule

/* rtl/core/discrete_inverse_cdf_sampler.sv */
// Top level of the discrete inverse CDF sampler.
// One request at a time, and the request side is ready again only once the
// result has moved into the output register. A load, or a sample on an empty,
// zero-total or single-entry table, goes through capture, table update or
// shortcut, and the result state. A full sample adds a binary search over the
// single-port prefix memory, with a read and a compare state per probe and up
// to ceil(log2(entries)) probes, and then two restoring divisions, the first
// skipped for a zero-weight bin. Each division takes one step per dividend
// bit; the dividend is WeightBits+ceil(log2(TableSize+1))+FracBits bits wide
// (51 at default sizes). A new result waits in the result state while the
// previous one has not yet been taken by the receiver.
module discrete_inverse_cdf_sampler
  import dics_pkg::*;
#(
  parameter int unsigned TableSize  = TableSizeDefault,
  parameter int unsigned WeightBits = WeightBitsDefault,
  parameter int unsigned FracBits   = FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic                    req_type_i,
  input  logic                    first_i,
  input  logic [WeightBits-1:0]   weight_i,
  input  logic [FracBits-1:0]     uniform_i,
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic [IndexOutBits-1:0] index_o,
  output logic [FxOutBits-1:0]    probability_o,
  output logic [FxOutBits-1:0]    reused_sample_o,
  output logic [StatusBits-1:0]   status_o
);

  dics_cmd_t  cmd;
  dics_stat_t stat;

  // Controller.
  dics_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .rsp_valid_o,
    .rsp_ready_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Datapath.
  dics_dp #(
    .TableSize  (TableSize),
    .WeightBits (WeightBits),
    .FracBits   (FracBits)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_type_i,
    .first_i,
    .weight_i,
    .uniform_i,
    .index_o,
    .probability_o,
    .reused_sample_o,
    .status_o
  );

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the discrete inverse CDF sampler.
module tb_top;
  import dics_pkg::*;

  localparam int unsigned NumTableEntries = TableSizeDefault;
  localparam longint unsigned OneFx = 64'd1 << FracBitsDefault;
  localparam int unsigned CycleLimit = 1500000;

  // One expected response of the block.
  typedef struct packed {
    logic [IndexOutBits-1:0] index;
    logic [FxOutBits-1:0]    probability;
    logic [FxOutBits-1:0]    reused_sample;
    logic [StatusBits-1:0]   status;
  } sampler_rsp_t;

  // Mirrors the weight table and predicts each response in order.
  class sampler_scoreboard;
    logic [WeightBitsDefault-1:0] weights[NumTableEntries];
    logic [25:0]                  prefix_sums[NumTableEntries];
    int unsigned                  entry_count;
    logic [25:0]                  total_weight;
    sampler_rsp_t                 expected_rsps[$];
    int unsigned                  mismatches;

    function new();
      entry_count = 0;
      total_weight = '0;
      mismatches = 0;
    endfunction

    // Works out the response to one accepted request.
    function void note_request(logic req_type, logic first, logic [15:0] weight,
                               logic [23:0] uniform);
      sampler_rsp_t     rsp;
      longint unsigned  scaled, prev, diff, quot, bin_weight;
      int unsigned      lo, hi, mid;
      rsp = '0;
      rsp.status = StatusOk;
      if (req_type == ReqLoad) begin
        if (first) begin
          entry_count = 0;
          total_weight = '0;
        end
        if (entry_count >= NumTableEntries) begin
          rsp.status = StatusFull;
        end else begin
          rsp.index = entry_count[IndexOutBits-1:0];
          total_weight = total_weight + 26'(weight);
          weights[entry_count] = weight;
          prefix_sums[entry_count] = total_weight;
          entry_count++;
        end
      end else if (entry_count == 0 || total_weight == 0) begin
        rsp.status = StatusEmpty;
      end else if (entry_count == 1) begin
        rsp.probability = FxOutBits'(OneFx);
        rsp.reused_sample = FxOutBits'(uniform);
      end else begin
        // Binary search for the first prefix sum not below the scaled value.
        scaled = 64'(uniform) * 64'(total_weight);
        lo = 0;
        hi = entry_count - 1;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if ((64'(prefix_sums[mid]) << FracBitsDefault) < scaled) lo = mid + 1;
          else hi = mid;
        end
        bin_weight = 64'(weights[lo]);
        prev = (lo > 0) ? (64'(prefix_sums[lo-1]) << FracBitsDefault) : 64'd0;
        diff = (scaled < prev) ? 64'd0 : scaled - prev;
        quot = (bin_weight > 0) ? diff / bin_weight : diff;
        if (quot > OneFx) quot = OneFx;
        rsp.index = lo[IndexOutBits-1:0];
        rsp.reused_sample = FxOutBits'(quot);
        quot = (bin_weight << FracBitsDefault) / 64'(total_weight);
        if (quot > OneFx) quot = OneFx;
        rsp.probability = FxOutBits'(quot);
      end
      expected_rsps.push_back(rsp);
    endfunction

    // Compares one accepted response with the oldest prediction.
    function void check_response(sampler_rsp_t actual);
      sampler_rsp_t want;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", actual);
        return;
      end
      want = expected_rsps.pop_front();
      if (want.index !== actual.index || want.probability !== actual.probability ||
          want.reused_sample !== actual.reused_sample || want.status !== actual.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected idx %0d prob %0h reused %0h status %0d,",
                    " got idx %0d prob %0h reused %0h status %0d"},
                   want.index, want.probability, want.reused_sample, want.status,
                   actual.index, actual.probability, actual.reused_sample, actual.status);
      end
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  logic                     req_type = ReqLoad;
  logic                     first = 1'b0;
  logic [15:0]              weight = '0;
  logic [23:0]              uniform = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  logic [IndexOutBits-1:0]  index;
  logic [FxOutBits-1:0]     probability;
  logic [FxOutBits-1:0]     reused_sample;
  logic [StatusBits-1:0]    status;

  sampler_scoreboard sb = new();
  bit                no_gaps = 1'b0;
  bit                rx_hold_req = 1'b0;
  int unsigned       cycle_count = 0;
  int unsigned       sent_items = 0;

  discrete_inverse_cdf_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_type_i     (req_type),
    .first_i        (first),
    .weight_i       (weight),
    .uniform_i      (uniform),
    .rsp_valid_o    (rsp_valid),
    .rsp_ready_i    (rsp_ready),
    .index_o        (index),
    .probability_o  (probability),
    .reused_sample_o(reused_sample),
    .status_o       (status)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(logic rt, logic fst, logic [15:0] w, logic [23:0] u);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_type <= rt;
    first <= fst;
    weight <= w;
    uniform <= u;
    do @(posedge clk_i); while (!req_ready);
    sb.note_request(rt, fst, w, u);
    sent_items++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] draw_weight();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Response side: random stalls, and one long hold when asked.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rsp_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid);
      sb.check_response({index, probability, reused_sample, status});
    end
  end

  // Request side: directed cases, table fill, then random distributions.
  initial begin
    int unsigned kind, n_loads, n_samples;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sample on an empty table after reset.
    send_request(ReqSample, 1'b0, 16'd0, 24'hFFFFFF);
    // Single entry with the largest weight.
    send_request(ReqLoad, 1'b1, 16'hFFFF, 24'd0);
    send_request(ReqSample, 1'b0, 16'd0, 24'd0);
    send_request(ReqSample, 1'b1, 16'hFFFF, 24'hFFFFFF);
    // Zero-total table.
    send_request(ReqLoad, 1'b1, 16'd0, 24'hFFFFFF);
    send_request(ReqLoad, 1'b0, 16'd0, 24'd0);
    send_request(ReqSample, 1'b0, 16'd0, 24'h123456);
    // Table with zero-weight bins in the middle and at the end.
    send_request(ReqLoad, 1'b1, 16'd5, 24'd0);
    send_request(ReqLoad, 1'b0, 16'd0, 24'd0);
    send_request(ReqLoad, 1'b0, 16'hFFFF, 24'd0);
    send_request(ReqLoad, 1'b0, 16'd1, 24'd0);
    send_request(ReqLoad, 1'b0, 16'd0, 24'd0);
    send_request(ReqSample, 1'b0, 16'd0, 24'd0);
    send_request(ReqSample, 1'b0, 16'd0, 24'hFFFFFF);
    send_request(ReqSample, 1'b0, 16'd0, 24'h800000);
    send_request(ReqSample, 1'b0, 16'd0, 24'h000001);

    // Fill the table, overflow it, sample it, then restart it while full.
    no_gaps = 1'b1;
    send_request(ReqLoad, 1'b1, draw_weight(), 24'($urandom));
    repeat (NumTableEntries - 1) send_request(ReqLoad, 1'b0, draw_weight(), 24'($urandom));
    send_request(ReqLoad, 1'b0, 16'hFFFF, 24'hFFFFFF);
    no_gaps = 1'b0;
    repeat (4) send_request(ReqSample, 1'b0, 16'($urandom), 24'($urandom));
    send_request(ReqSample, 1'b0, 16'd0, 24'hFFFFFF);
    send_request(ReqLoad, 1'b1, 16'd7, 24'd0);

    // Random distributions with samples, plus noise.
    sent_items = 0;
    while (sent_items < 650) begin
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      if (sent_items > 150 && sent_items < 160 && !rx_hold_req) rx_hold_req = 1'b1;
      if (sent_items > 300 && sent_items < 305) wait_drained();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        n_loads = $urandom_range(1, 12);
        n_samples = $urandom_range(1, 6);
        send_request(ReqLoad, 1'b1, draw_weight(), 24'($urandom));
        repeat (n_loads - 1) send_request(ReqLoad, 1'b0, draw_weight(), 24'($urandom));
        repeat (n_samples) send_request(ReqSample, 1'($urandom_range(0, 1)),
                                        16'($urandom), 24'($urandom));
      end else if (kind == 7) begin
        send_request(ReqLoad, 1'($urandom_range(0, 1)), draw_weight(), 24'($urandom));
      end else if (kind == 8) begin
        send_request(ReqSample, 1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom));
      end else begin
        send_request(ReqLoad, 1'b1, 16'd0, 24'($urandom));
        send_request(ReqLoad, 1'b0, 16'd0, 24'($urandom));
        send_request(ReqSample, 1'b0, 16'($urandom), 24'($urandom));
      end
    end
    req_valid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
